@@ rtl/scmi_pkg.sv @@
`timescale 1ns / 1ps

// Shared codes, constants and types of the serial command interpreter.
package scmi_pkg;

   // Pending command modes.
   localparam logic [3:0] MODE_IDLE = 4'd0;
   localparam logic [3:0] MODE_T    = 4'd1;
   localparam logic [3:0] MODE_D    = 4'd2;
   localparam logic [3:0] MODE_B    = 4'd3;
   localparam logic [3:0] MODE_W    = 4'd4;
   localparam logic [3:0] MODE_R    = 4'd5;
   localparam logic [3:0] MODE_LE   = 4'd6;
   localparam logic [3:0] MODE_UE   = 4'd7;
   localparam logic [3:0] MODE_P    = 4'd8;
   localparam logic [3:0] MODE_H    = 4'd9;
   localparam logic [3:0] MODE_L    = 4'd10;

   // Action codes on the result channel.
   localparam logic [3:0] ACT_NONE   = 4'd0;
   localparam logic [3:0] ACT_THRESH = 4'd1;
   localparam logic [3:0] ACT_WAKE   = 4'd2;
   localparam logic [3:0] ACT_SWR    = 4'd3;
   localparam logic [3:0] ACT_SRD    = 4'd4;
   localparam logic [3:0] ACT_NVWR   = 4'd5;
   localparam logic [3:0] ACT_NVRD   = 4'd6;
   localparam logic [3:0] ACT_SLEEP  = 4'd7;
   localparam logic [3:0] ACT_PINRD  = 4'd8;
   localparam logic [3:0] ACT_PINHI  = 4'd9;
   localparam logic [3:0] ACT_PINLO  = 4'd10;

   // Reply status codes.
   localparam logic [1:0] REPLY_SILENT = 2'd0;
   localparam logic [1:0] REPLY_OK     = 2'd1;
   localparam logic [1:0] REPLY_ERR    = 2'd2;

   // Numeric constants.
   localparam logic [15:0] WAKE_MAX      = 16'd63535;
   localparam logic [15:0] SLEEP_PRELOAD = 16'd65500;

   // ASCII characters that the interpreter recognizes.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_E  = 8'h45;
   localparam logic [7:0] CHAR_UC_H  = 8'h48;
   localparam logic [7:0] CHAR_UC_L  = 8'h4C;
   localparam logic [7:0] CHAR_LC_B  = 8'h62;
   localparam logic [7:0] CHAR_LC_D  = 8'h64;
   localparam logic [7:0] CHAR_LC_E  = 8'h65;
   localparam logic [7:0] CHAR_LC_P  = 8'h70;
   localparam logic [7:0] CHAR_LC_R  = 8'h72;
   localparam logic [7:0] CHAR_LC_T  = 8'h74;
   localparam logic [7:0] CHAR_LC_W  = 8'h77;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

   // Interpreter context carried from one byte to the next.
   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] acc;
      logic [7:0]  data_byte;
   } ctx_type;

   // One result item.
   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  target;
      logic [15:0] payload;
      logic [1:0]  reply;
   } result_type;

endpackage

@@ rtl/scmi_decode.sv @@
`timescale 1ns / 1ps

// Combinational decode of one received byte against the current context.
module scmi_decode (
   input  logic [7:0]           rx_byte,
   input  scmi_pkg::ctx_type    ctx_cur,
   output scmi_pkg::ctx_type    ctx_nxt,
   output scmi_pkg::result_type result
);

   logic        eol;
   logic        is_digit;
   logic        is_pin_digit;
   logic [3:0]  letter_mode;
   logic [3:0]  pin_action;
   logic [15:0] digit_value;
   logic [15:0] acc_times_ten;
   logic [15:0] wake_offset;

   // Character classification.
   assign eol          = (rx_byte == scmi_pkg::CHAR_LF) || (rx_byte == scmi_pkg::CHAR_CR);
   assign is_digit     = rx_byte inside {[scmi_pkg::CHAR_ZERO:scmi_pkg::CHAR_NINE]};
   assign is_pin_digit = (rx_byte inside {[scmi_pkg::CHAR_ZERO:scmi_pkg::CHAR_THREE]})
                         || (rx_byte == scmi_pkg::CHAR_SIX);
   assign digit_value  = {8'd0, rx_byte - scmi_pkg::CHAR_ZERO};

   // Accumulator times ten as two shifted adds; the sum wraps at 16 bits.
   assign acc_times_ten = {ctx_cur.acc[12:0], 3'b000} + {ctx_cur.acc[14:0], 1'b0};

   // The wake offset is 65535 minus the accumulator, clamped.
   assign wake_offset = (~ctx_cur.acc > scmi_pkg::WAKE_MAX) ? scmi_pkg::WAKE_MAX
                                                            : ~ctx_cur.acc;

   // Command letter lookup.
   always_comb begin
      case (rx_byte)
         scmi_pkg::CHAR_LC_T: letter_mode = scmi_pkg::MODE_T;
         scmi_pkg::CHAR_LC_D: letter_mode = scmi_pkg::MODE_D;
         scmi_pkg::CHAR_LC_B: letter_mode = scmi_pkg::MODE_B;
         scmi_pkg::CHAR_LC_W: letter_mode = scmi_pkg::MODE_W;
         scmi_pkg::CHAR_LC_R: letter_mode = scmi_pkg::MODE_R;
         scmi_pkg::CHAR_LC_E: letter_mode = scmi_pkg::MODE_LE;
         scmi_pkg::CHAR_UC_E: letter_mode = scmi_pkg::MODE_UE;
         scmi_pkg::CHAR_LC_P: letter_mode = scmi_pkg::MODE_P;
         scmi_pkg::CHAR_UC_H: letter_mode = scmi_pkg::MODE_H;
         scmi_pkg::CHAR_UC_L: letter_mode = scmi_pkg::MODE_L;
         default:             letter_mode = scmi_pkg::MODE_IDLE;
      endcase
   end

   // Pin command mode to its action.
   always_comb begin
      case (ctx_cur.mode)
         scmi_pkg::MODE_P: pin_action = scmi_pkg::ACT_PINRD;
         scmi_pkg::MODE_H: pin_action = scmi_pkg::ACT_PINHI;
         default:          pin_action = scmi_pkg::ACT_PINLO;
      endcase
   end

   // Main command decode.
   always_comb begin
      ctx_nxt = ctx_cur;
      result  = '{action:  scmi_pkg::ACT_NONE, target: 8'd0,
                  payload: 16'd0, reply: scmi_pkg::REPLY_SILENT};

      if (eol && (ctx_cur.mode == scmi_pkg::MODE_IDLE)) begin
         // A line end with nothing pending is dropped silently.
      end else if (eol) begin
         // A line end executes the pending command.
         case (ctx_cur.mode)
            scmi_pkg::MODE_T: begin
               result.action  = scmi_pkg::ACT_THRESH;
               result.payload = ctx_cur.acc;
            end
            scmi_pkg::MODE_D: begin
               result.action  = scmi_pkg::ACT_WAKE;
               result.payload = wake_offset;
            end
            scmi_pkg::MODE_B: begin
               ctx_nxt.data_byte = ctx_cur.acc[7:0];
            end
            scmi_pkg::MODE_W: begin
               result.action  = scmi_pkg::ACT_SWR;
               result.target  = ctx_cur.acc[7:0];
               result.payload = {8'd0, ctx_cur.data_byte};
            end
            scmi_pkg::MODE_R: begin
               result.action = scmi_pkg::ACT_SRD;
               result.target = ctx_cur.acc[7:0];
            end
            scmi_pkg::MODE_LE: begin
               result.action  = scmi_pkg::ACT_NVWR;
               result.target  = ctx_cur.acc[7:0];
               result.payload = {8'd0, ctx_cur.data_byte};
            end
            scmi_pkg::MODE_UE: begin
               result.action = scmi_pkg::ACT_NVRD;
               result.target = ctx_cur.acc[7:0];
            end
            default: begin
               // Pin commands and unused codes do nothing on a line end.
            end
         endcase
         ctx_nxt.acc  = 16'd0;
         ctx_nxt.mode = scmi_pkg::MODE_IDLE;
         result.reply = scmi_pkg::REPLY_OK;
      end else if ((ctx_cur.mode == scmi_pkg::MODE_IDLE)
                   && ((rx_byte == scmi_pkg::CHAR_LC_Z)
                       || (letter_mode != scmi_pkg::MODE_IDLE))) begin
         // A command letter while idle; sleep runs at once.
         if (rx_byte == scmi_pkg::CHAR_LC_Z) begin
            result.action  = scmi_pkg::ACT_SLEEP;
            result.payload = scmi_pkg::SLEEP_PRELOAD;
         end else begin
            ctx_nxt.mode = letter_mode;
         end
      end else if (ctx_cur.mode inside {[scmi_pkg::MODE_P:scmi_pkg::MODE_L]}) begin
         // The pin commands complete on the next byte.
         ctx_nxt.mode = scmi_pkg::MODE_IDLE;
         if (is_pin_digit) begin
            result.action = pin_action;
            result.target = rx_byte - scmi_pkg::CHAR_ZERO;
         end else begin
            result.reply = scmi_pkg::REPLY_ERR;
         end
      end else if ((ctx_cur.mode inside {[scmi_pkg::MODE_T:scmi_pkg::MODE_UE]}) && is_digit) begin
         // Decimal digit accumulation.
         ctx_nxt.acc = acc_times_ten + digit_value;
      end else begin
         // Anything else aborts the command; the accumulator is kept.
         ctx_nxt.mode = scmi_pkg::MODE_IDLE;
         result.reply = scmi_pkg::REPLY_ERR;
      end
   end

endmodule

@@ rtl/serial_command_interpreter.sv @@
`timescale 1ns / 1ps

// Serial command interpreter.
// The req_ channel takes one received ASCII byte per transaction on
// req_rx_byte. Every byte produces exactly one transaction on the rsp_
// channel: an action code, a target address or pin, a payload and a reply
// status. The actual device accesses are done by logic downstream.
// An accepted byte is held in the input register, decoded combinationally
// and registered in the result register that drives the rsp_ ports.
// Throughput: one byte per cycle while rsp_ready is high, set by the single
// decode stage between the input register and the result register; the
// command context updates in the same cycle that a result is registered,
// so consecutive bytes see it. When rsp_ready is low the result register
// holds its transaction, the input register holds the next byte, and
// req_ready drops once both are full. At reset (synchronous, active high)
// both registers empty, the pending command returns to idle and the
// accumulator and buffered data byte clear to zero.
module serial_command_interpreter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_action,
   output logic [7:0]  rsp_target,
   output logic [15:0] rsp_payload,
   output logic [1:0]  rsp_reply
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   scmi_pkg::result_type out_result_ff;
   scmi_pkg::ctx_type    ctx_ff;
   scmi_pkg::ctx_type    ctx_in;
   scmi_pkg::result_type dec_result;
   logic                 advance;

   // The held byte moves on when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Byte decode against the current context.
   scmi_decode u_decode (
      .rx_byte (in_byte_ff),
      .ctx_cur (ctx_ff),
      .ctx_nxt (ctx_in),
      .result  (dec_result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Command context, updated once per decoded byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '{mode: scmi_pkg::MODE_IDLE, acc: 16'd0, data_byte: 8'd0};
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_result_ff <= dec_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_action  = out_result_ff.action;
   assign rsp_target  = out_result_ff.target;
   assign rsp_payload = out_result_ff.payload;
   assign rsp_reply   = out_result_ff.reply;

endmodule

@@ rtl/scmi_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks of the serial command interpreter.
module scmi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_action,
   input logic [7:0]  rsp_target,
   input logic [15:0] rsp_payload,
   input logic [1:0]  rsp_reply
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_target) && $stable(rsp_payload) && $stable(rsp_reply))
      else $error("stalled result transaction changed");

   // The reply is never the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reply != 2'd3)
      else $error("unused reply code");

   // Sleep always carries the timer preload and a silent reply.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == scmi_pkg::ACT_SLEEP
         |-> rsp_payload == scmi_pkg::SLEEP_PRELOAD && rsp_reply == scmi_pkg::REPLY_SILENT)
      else $error("bad sleep result");

   // The wake offset never exceeds its clamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == scmi_pkg::ACT_WAKE |-> rsp_payload <= scmi_pkg::WAKE_MAX)
      else $error("wake offset above clamp");

   // Pin actions name a legal pin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == scmi_pkg::ACT_PINRD || rsp_action == scmi_pkg::ACT_PINHI
                    || rsp_action == scmi_pkg::ACT_PINLO)
         |-> rsp_target <= 8'd3 || rsp_target == 8'd6)
      else $error("illegal pin number");

endmodule

bind serial_command_interpreter scmi_checker u_scmi_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_action  (rsp_action),
   .rsp_target  (rsp_target),
   .rsp_payload (rsp_payload),
   .rsp_reply   (rsp_reply)
);
